// ----- rtl/integer_to_radix_digits_core_assert.svh -----
// ----------------------------------------------------------------------------
// integer_to_radix_digits_core assertion macros
// Concurrent assertion shorthands, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_RADIX_DIGITS_CORE_ASSERT_SVH
`define INTEGER_TO_RADIX_DIGITS_CORE_ASSERT_SVH

// check a property on every rising edge outside reset
`define ITRD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that a condition never holds outside reset
`define ITRD_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/itrd_pkg.sv -----
// ----------------------------------------------------------------------------
// itrd_pkg
// Shared constants and helpers of the radix digit converter.
// ----------------------------------------------------------------------------
package itrd_pkg;

    localparam int RADIX_W     = 6;
    localparam int CHAR_W      = 7;
    localparam int MAX_RESULTS = 31;
    localparam int EMIT_W      = 5;
    localparam int DIV_STEP    = 8;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_ALPHA = 7'h41;
    localparam logic [RADIX_W-1:0] DEC_TEN   = 6'd10;
    localparam logic [RADIX_W-1:0] DEC_NINE  = 6'd9;

    localparam logic REG_RADIX = 1'b0;

    function automatic logic [CHAR_W-1:0] digit_ascii(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d <= DEC_NINE)
        begin
            c = CHAR_ZERO + CHAR_W'(d);
        end
        else
        begin
            c = CHAR_ALPHA + CHAR_W'(d - DEC_TEN);
        end
        return c;
    endfunction

endpackage

// ----- rtl/itrd_in_if.sv -----
// ----------------------------------------------------------------------------
// itrd_in_if
// Input channel: one signed integer per transaction.
// ----------------------------------------------------------------------------
interface itrd_in_if #(
    parameter int VALUE_BITS = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

// ----- rtl/itrd_out_if.sv -----
// ----------------------------------------------------------------------------
// itrd_out_if
// Output channel: one ASCII digit per transaction.
// ----------------------------------------------------------------------------
interface itrd_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] digit_char;
    logic       last;
    logic       empty_res;

    modport source (output valid, output digit_char, output last, output empty_res, input ready);
    modport sink   (input valid, input digit_char, input last, input empty_res, output ready);
endinterface

// ----- rtl/integer_to_radix_digits_core.sv -----
// ----------------------------------------------------------------------------
// integer_to_radix_digits_core
// Converts a signed integer to ASCII digits of a programmable radix.
// ----------------------------------------------------------------------------
// Usage:
//   din  : one signed value per transaction; ready only while idle.
//   dout : digits most significant first, last set on the final digit.
//          A zero or negative value gives one transaction with empty_res
//          and last set and digit_char zero.
//   APB  : register 0 (byte address 0) holds the radix, 6 bits, reset 10;
//          values outside 2..36 saturate. Write only while idle.
// Timing:
//   The divider retires 8 quotient bits per cycle, so one pass over the
//   value yields one digit. The digit stack then pops each digit through a
//   read state and a present state, the latter held while the receiver
//   stalls. At most 31 digits are emitted, the most significant ones.
// Reset clears the sequencer and sets the radix to 10. A stalled receiver
// holds the current digit; the sequencer waits in place.
// ----------------------------------------------------------------------------
module integer_to_radix_digits_core
    import itrd_pkg::*;
#(
    parameter int MAX_DIGITS = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    itrd_in_if.sink             din,
    itrd_out_if.source          dout
);

    localparam int CHUNKS = (VALUE_BITS + DIV_STEP - 1) / DIV_STEP;
    localparam int QW     = CHUNKS * DIV_STEP;
    localparam int CKW    = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam int AW     = $clog2(MAX_DIGITS);
    localparam int CW     = $clog2(MAX_DIGITS + 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_RD   = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    logic [RADIX_W-1:0]   radix_reg;
    logic [RADIX_W-1:0]   base_reg, base_next;
    logic [QW-1:0]        quo_reg, quo_next;
    logic [RADIX_W-1:0]   rem_reg, rem_next;
    logic [CKW-1:0]       chunk_reg, chunk_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [EMIT_W-1:0]    emit_reg, emit_next;
    logic                 last_reg, last_next;
    logic                 empty_reg, empty_next;
    logic [RADIX_W-1:0]   dig_reg;

    logic [RADIX_W-1:0]   mem [MAX_DIGITS];
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [AW-1:0]        mem_raddr;

    logic [RADIX_W-1:0]   step_rem;
    logic [DIV_STEP-1:0]  step_q;
    logic [QW-1:0]        quo_shift;
    logic [RADIX_W-1:0]   base_clamp;
    logic [CW-1:0]        count_after;
    logic                 in_fire;
    logic                 out_fire;
    logic                 value_pos;

    assign pready = 1'b1;
    assign prdata = 32'(radix_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= RADIX_RESET;
        end
        else if (psel && penable && pwrite && paddr[2] == REG_RADIX)
        begin
            radix_reg <= pwdata[RADIX_W-1:0];
        end
    end

    assign in_fire   = din.valid && din.ready;
    assign out_fire  = dout.valid && dout.ready;
    assign value_pos = !din.value[VALUE_BITS-1] && (din.value != '0);

    always_comb
    begin
        if (radix_reg < RADIX_MIN)
        begin
            base_clamp = RADIX_MIN;
        end
        else if (radix_reg > RADIX_MAX)
        begin
            base_clamp = RADIX_MAX;
        end
        else
        begin
            base_clamp = radix_reg;
        end
    end

    always_comb
    begin
        logic [RADIX_W:0]   t;
        logic [RADIX_W-1:0] r;
        r      = rem_reg;
        step_q = '0;
        for (int i = 0; i < DIV_STEP; i++)
        begin
            t = {r, quo_reg[QW-1-i]};
            if (t >= {1'b0, base_reg})
            begin
                r                     = RADIX_W'(t - {1'b0, base_reg});
                step_q[DIV_STEP-1-i]  = 1'b1;
            end
            else
            begin
                r = t[RADIX_W-1:0];
            end
        end
        step_rem  = r;
        quo_shift = (quo_reg << DIV_STEP) | QW'(step_q);
    end

    assign count_after = (count_reg < CW'(MAX_DIGITS)) ? count_reg + 1'b1 : count_reg;
    assign mem_waddr   = count_reg[AW-1:0];
    assign mem_raddr   = AW'(count_reg - 1'b1);
    assign mem_we      = (state_reg == ST_DIV) && (chunk_reg == CKW'(CHUNKS - 1))
                         && (count_reg < CW'(MAX_DIGITS));

    always_comb
    begin
        state_next = state_reg;
        base_next  = base_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        chunk_next = chunk_reg;
        count_next = count_reg;
        emit_next  = emit_reg;
        last_next  = last_reg;
        empty_next = empty_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    base_next  = base_clamp;
                    quo_next   = QW'($unsigned(din.value));
                    rem_next   = '0;
                    chunk_next = '0;
                    count_next = '0;
                    if (value_pos)
                    begin
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        emit_next  = '0;
                        last_next  = 1'b1;
                        empty_next = 1'b1;
                        state_next = ST_OUT;
                    end
                end
            end
            ST_DIV:
            begin
                quo_next = quo_shift;
                if (chunk_reg == CKW'(CHUNKS - 1))
                begin
                    chunk_next = '0;
                    rem_next   = '0;
                    count_next = count_after;
                    if (quo_shift == '0)
                    begin
                        if (32'(count_after) > 32'(MAX_RESULTS))
                        begin
                            emit_next = EMIT_W'(MAX_RESULTS);
                        end
                        else
                        begin
                            emit_next = EMIT_W'(count_after);
                        end
                        state_next = ST_RD;
                    end
                end
                else
                begin
                    rem_next   = step_rem;
                    chunk_next = chunk_reg + 1'b1;
                end
            end
            ST_RD:
            begin
                count_next = count_reg - 1'b1;
                emit_next  = emit_reg - 1'b1;
                last_next  = (emit_reg == EMIT_W'(1));
                empty_next = 1'b0;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_fire)
                begin
                    if (emit_reg == '0)
                    begin
                        count_next = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            chunk_reg <= '0;
            count_reg <= '0;
            emit_reg  <= '0;
            last_reg  <= 1'b0;
            empty_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            chunk_reg <= chunk_next;
            count_reg <= count_next;
            emit_reg  <= emit_next;
            last_reg  <= last_next;
            empty_reg <= empty_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= step_rem;
        end
        if (state_reg == ST_RD)
        begin
            dig_reg <= mem[mem_raddr];
        end
    end

    assign din.ready       = (state_reg == ST_IDLE);
    assign dout.valid      = (state_reg == ST_OUT);
    assign dout.last       = last_reg;
    assign dout.empty_res  = empty_reg;
    assign dout.digit_char = empty_reg ? '0 : digit_ascii(dig_reg);

endmodule

// ----- rtl/itrd_checker.sv -----
// ----------------------------------------------------------------------------
// itrd_checker
// Port-level checks of the radix digit converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "integer_to_radix_digits_core_assert.svh"

module itrd_checker #(
    parameter int VALUE_BITS = 32
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic signed [VALUE_BITS-1:0] in_value,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [6:0]                   out_digit_char,
    input logic                         out_last,
    input logic                         out_empty_res
);

    `ITRD_ASSERT(a_empty_shape, clk, rst_n, out_valid && out_empty_res |-> out_last && out_digit_char == 7'd0, "empty transaction must be last with zero character")

    `ITRD_ASSERT_NEVER(a_no_overlap, clk, rst_n, in_ready && out_valid, "input taken while a digit is pending")

    `ITRD_ASSERT(a_nonpos_empty, clk, rst_n, in_valid && in_ready && (in_value[VALUE_BITS-1] || in_value == '0) |=> out_valid && out_empty_res, "non-positive value must give an empty transaction")

    `ITRD_ASSERT(a_char_range, clk, rst_n, out_valid && !out_empty_res |-> (out_digit_char >= 7'h30 && out_digit_char <= 7'h39) || (out_digit_char >= 7'h41 && out_digit_char <= 7'h5A), "digit character out of range")

    `ITRD_ASSERT(a_idle_after_last, clk, rst_n, out_valid && out_ready && out_last |=> in_ready, "converter not idle after the last digit")

endmodule

bind integer_to_radix_digits_core itrd_checker #(
    .VALUE_BITS (VALUE_BITS)
) u_itrd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (din.valid),
    .in_ready       (din.ready),
    .in_value       (din.value),
    .out_valid      (dout.valid),
    .out_ready      (dout.ready),
    .out_digit_char (dout.digit_char),
    .out_last       (dout.last),
    .out_empty_res  (dout.empty_res)
);

// ----- tb/sv/integer_to_radix_digits_core_tb.sv -----
// ----------------------------------------------------------------------------
// integer_to_radix_digits_core_tb
// Self-checking bench for the radix digit converter. Signed values go in over
// the input channel, and the ASCII digit transactions that come back are
// compared field by field against a local predictor. The radix is programmed
// over APB with both in-range and saturating values. Both channels idle at
// random in the drain test and in all but one random phase.
// ----------------------------------------------------------------------------
module integer_to_radix_digits_core_tb;
    import itrd_pkg::*;

    localparam int MAX_DIGITS = 32;
    localparam int VALUE_BITS = 32;
    localparam int PHASE_ITEMS = 28;

    localparam logic [2:0] ADDR_RADIX    = {REG_RADIX, 2'b00};
    localparam logic [2:0] ADDR_UNMAPPED = 3'd4;

    typedef struct packed {
        logic [CHAR_W-1:0] digit_char;
        logic              last;
        logic              empty_res;
    } digit_txn_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    itrd_in_if #(.VALUE_BITS(VALUE_BITS)) din_if ();
    itrd_out_if                           dout_if ();

    digit_txn_t        digit_queue[$];
    logic [RADIX_W-1:0] radix_reg;
    int                mismatch_count = 0;
    bit                src_gaps_on = 1'b0;
    bit                sink_gaps_on = 1'b0;
    int                sink_stall_left = 0;
    int                sink_roll;

    integer_to_radix_digits_core #(
        .MAX_DIGITS(MAX_DIGITS),
        .VALUE_BITS(VALUE_BITS)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .din     (din_if),
        .dout    (dout_if)
    );

    always #6 clk = ~clk;

    function automatic void note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("%0t: %s", $time, msg);
        end
    endfunction

    function automatic logic [RADIX_W-1:0] effective_radix();
        if (radix_reg < RADIX_MIN)
        begin
            return RADIX_MIN;
        end
        if (radix_reg > RADIX_MAX)
        begin
            return RADIX_MAX;
        end
        return radix_reg;
    endfunction

    function automatic void push_expected_digits(input logic signed [VALUE_BITS-1:0] v);
        logic [RADIX_W-1:0]    base;
        logic [RADIX_W-1:0]    held [MAX_DIGITS];
        logic [VALUE_BITS-2:0] q;
        logic [RADIX_W-1:0]    d;
        int                    held_n;
        int                    emit;
        digit_txn_t            t;
        base = effective_radix();
        if (v <= 0)
        begin
            t.digit_char = '0;
            t.last       = 1'b1;
            t.empty_res  = 1'b1;
            digit_queue.push_back(t);
            return;
        end
        q = v[VALUE_BITS-2:0];
        held_n = 0;
        while (q != 0)
        begin
            if (held_n < MAX_DIGITS)
            begin
                held[held_n] = RADIX_W'(q % base);
                held_n++;
            end
            q = q / base;
        end
        emit = (held_n > MAX_RESULTS) ? MAX_RESULTS : held_n;
        for (int k = 0; k < emit; k++)
        begin
            d = held[held_n - 1 - k];
            if (d <= DEC_NINE)
            begin
                t.digit_char = CHAR_ZERO + CHAR_W'(d);
            end
            else
            begin
                t.digit_char = CHAR_ALPHA + CHAR_W'(d - DEC_TEN);
            end
            t.last      = (k + 1 == emit);
            t.empty_res = 1'b0;
            digit_queue.push_back(t);
        end
    endfunction

    function automatic int pick_gap();
        int r;
        if (!src_gaps_on)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 30);
    endfunction

    function automatic logic signed [VALUE_BITS-1:0] rand_value();
        int          r;
        longint      p;
        longint      top;
        int          steps;
        logic [31:0] raw;
        r = $urandom_range(0, 99);
        raw = $urandom;
        if (r < 8)
        begin
            return raw | 32'h8000_0000;
        end
        if (r < 10)
        begin
            return '0;
        end
        if (r < 25)
        begin
            top = 64'h7FFF_FFFF;
            p = 1;
            steps = $urandom_range(1, 31);
            while (steps > 0 && p * effective_radix() <= top)
            begin
                p = p * effective_radix();
                steps--;
            end
            return VALUE_BITS'(p - $urandom_range(0, 1));
        end
        return raw >> $urandom_range(1, 31);
    endfunction

    task automatic send_value(input logic signed [VALUE_BITS-1:0] v);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            din_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        din_if.valid <= 1'b1;
        din_if.value <= v;
        do @(posedge clk); while (!din_if.ready);
        push_expected_digits(v);
    endtask

    task automatic settle_idle();
        @(negedge clk);
        din_if.valid <= 1'b0;
        while (digit_queue.size() != 0) @(posedge clk);
        do @(posedge clk); while (!din_if.ready);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (addr[2] == REG_RADIX)
        begin
            radix_reg = data[RADIX_W-1:0];
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_radix_readback();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_RADIX;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== 32'(radix_reg))
        begin
            note_mismatch($sformatf("radix readback: expected %h, got %h",
                32'(radix_reg), prdata));
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_radix(input logic [RADIX_W-1:0] r);
        settle_idle();
        write_reg(ADDR_RADIX, ($urandom & ~32'h3F) | 32'(r));
        check_radix_readback();
    endtask

    task automatic test_default_radix();
        send_value(0);
        send_value(-1);
        send_value(1);
        send_value(9);
        send_value(10);
        send_value(123456789);
        send_value(32'sh7FFF_FFFF);
        send_value(32'sh8000_0000);
    endtask

    task automatic test_radix_extremes();
        set_radix(6'd2);
        send_value(1);
        send_value(32'sh7FFF_FFFF);
        send_value(32'sh5555_5555);
        set_radix(6'd36);
        send_value(35);
        send_value(36);
        send_value(32'sh7FFF_FFFF);
        set_radix(6'd16);
        send_value(32'sh7ABC_DEF0);
        set_radix(6'd0);
        send_value(6);
        set_radix(6'd1);
        send_value(5);
        set_radix(6'd63);
        send_value(35);
        set_radix(6'd37);
        send_value(36);
    endtask

    task automatic test_unmapped_write();
        settle_idle();
        write_reg(ADDR_UNMAPPED, 32'hFFFF_FFFF);
        check_radix_readback();
        send_value(100);
    endtask

    task automatic test_pause_for_drain();
        src_gaps_on  = 1'b1;
        sink_gaps_on = 1'b1;
        set_radix(6'd8);
        repeat (3)
        begin
            repeat ($urandom_range(2, 5)) send_value(rand_value());
            settle_idle();
        end
    endtask

    task automatic test_random_phases();
        logic [RADIX_W-1:0] plan [9];
        plan = '{6'd2, 6'd36, 6'd0, 6'd63, 6'd10, 6'd16, 6'd1, 6'd37,
            RADIX_W'($urandom_range(3, 35))};
        foreach (plan[i])
        begin
            set_radix(plan[i]);
            src_gaps_on  = (i != 4);
            sink_gaps_on = (i != 4);
            repeat (PHASE_ITEMS) send_value(rand_value());
        end
    endtask

    always @(negedge clk)
    begin
        if (!sink_gaps_on)
        begin
            dout_if.ready <= 1'b1;
        end
        else if (sink_stall_left > 0)
        begin
            dout_if.ready   <= 1'b0;
            sink_stall_left <= sink_stall_left - 1;
        end
        else
        begin
            sink_roll = $urandom_range(0, 99);
            if (sink_roll < 60)
            begin
                dout_if.ready <= 1'b1;
            end
            else if (sink_roll < 94)
            begin
                dout_if.ready   <= 1'b0;
                sink_stall_left <= $urandom_range(0, 2);
            end
            else
            begin
                dout_if.ready   <= 1'b0;
                sink_stall_left <= $urandom_range(8, 30);
            end
        end
    end

    always @(posedge clk)
    begin
        digit_txn_t want;
        if (rst_n && dout_if.valid && dout_if.ready)
        begin
            if (digit_queue.size() == 0)
            begin
                note_mismatch($sformatf("unexpected transaction: char %h last %b empty %b",
                    dout_if.digit_char, dout_if.last, dout_if.empty_res));
            end
            else
            begin
                want = digit_queue.pop_front();
                if (dout_if.digit_char !== want.digit_char || dout_if.last !== want.last
                    || dout_if.empty_res !== want.empty_res)
                begin
                    note_mismatch($sformatf(
                        "digit mismatch: expected char %h last %b empty %b, got %h %b %b",
                        want.digit_char, want.last, want.empty_res,
                        dout_if.digit_char, dout_if.last, dout_if.empty_res));
                end
            end
        end
    end

    initial
    begin
        #(24_000_000);
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        din_if.valid  = 1'b0;
        din_if.value  = '0;
        dout_if.ready = 1'b0;
        radix_reg     = RADIX_RESET;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_default_radix();
        test_radix_extremes();
        test_unmapped_write();
        test_pause_for_drain();
        test_random_phases();

        settle_idle();
        repeat (250) @(posedge clk);
        if (mismatch_count == 0 && digit_queue.size() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
